[sv/pidm_pkg.sv]
// ----------------------------------------------------------------------------
// pidm_pkg
// Shared types, constants and the control store of the position motor drive.
// ----------------------------------------------------------------------------
package pidm_pkg;

  // Parameter defaults
  localparam int POSITION_BITS_DEF      = 32;
  localparam int GAIN_FRACTION_BITS_DEF = 8;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_P       = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_I       = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_D       = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACCELERATION = 2'd3;

  // Configuration reset values
  localparam logic signed [15:0] GAIN_P_RESET       = 16'sd256;
  localparam logic signed [15:0] GAIN_I_RESET       = 16'sd0;
  localparam logic signed [15:0] GAIN_D_RESET       = 16'sd0;
  localparam logic        [15:0] ACCELERATION_RESET = 16'd0;

  // Input item
  typedef struct packed {
    logic               op;
    logic signed [15:0] speed_command;
    logic signed [31:0] target_position;
    logic signed [31:0] measured_position;
    logic        [15:0] elapsed_ms;
  } in_t;

  // Result item
  typedef struct packed {
    logic signed [7:0] speed;
    logic        [7:0] forward_duty;
    logic        [7:0] reverse_duty;
  } out_t;

  // Configuration register file contents
  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic        [15:0] acceleration;
  } cfg_t;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    DP_LOAD,
    DP_NOP,
    DP_SET,
    DP_ERR,
    DP_INTDER,
    DP_MUL_P,
    DP_MUL_I,
    DP_MUL_D,
    DP_ACC,
    DP_DIV,
    DP_MAP,
    DP_STEP,
    DP_SLEW,
    DP_QUO,
    DP_EMIT
  } dp_op_t;

  // Conditions that hold the step counter in place
  typedef enum logic [1:0] {
    H_NONE,
    H_NO_INPUT,
    H_OUT_FULL
  } hold_t;

  // Conditions that take the jump target
  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_IS_SET,
    J_SPEED_ZERO,
    J_IN_REACH
  } jump_t;

  localparam int PC_BITS = 4;

  // Step addresses
  localparam logic [PC_BITS-1:0] PC_FETCH  = 4'd0;
  localparam logic [PC_BITS-1:0] PC_DISP   = 4'd1;
  localparam logic [PC_BITS-1:0] PC_CHECK  = 4'd2;
  localparam logic [PC_BITS-1:0] PC_ERR    = 4'd3;
  localparam logic [PC_BITS-1:0] PC_INTDER = 4'd4;
  localparam logic [PC_BITS-1:0] PC_MUL_P  = 4'd5;
  localparam logic [PC_BITS-1:0] PC_MUL_I  = 4'd6;
  localparam logic [PC_BITS-1:0] PC_MUL_D  = 4'd7;
  localparam logic [PC_BITS-1:0] PC_ACC    = 4'd8;
  localparam logic [PC_BITS-1:0] PC_DIV    = 4'd9;
  localparam logic [PC_BITS-1:0] PC_MAP    = 4'd10;
  localparam logic [PC_BITS-1:0] PC_STEP   = 4'd11;
  localparam logic [PC_BITS-1:0] PC_SLEW   = 4'd12;
  localparam logic [PC_BITS-1:0] PC_QUO    = 4'd13;
  localparam logic [PC_BITS-1:0] PC_EMIT   = 4'd14;
  localparam logic [PC_BITS-1:0] PC_SET    = 4'd15;

  // One control word
  typedef struct packed {
    dp_op_t               op;
    hold_t                hold;
    jump_t                jump;
    logic [PC_BITS-1:0]   target;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    dp_op_t op;
    logic   exec;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic is_set;
    logic speed_zero;
    logic in_reach;
    logic out_full;
  } stat_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
    ucode_t w;
    case (pc)
      PC_FETCH:  w = '{DP_LOAD,   H_NO_INPUT, J_NEXT,       PC_FETCH};
      PC_DISP:   w = '{DP_NOP,    H_NONE,     J_IS_SET,     PC_SET};
      PC_CHECK:  w = '{DP_NOP,    H_NONE,     J_SPEED_ZERO, PC_EMIT};
      PC_ERR:    w = '{DP_ERR,    H_NONE,     J_NEXT,       PC_FETCH};
      PC_INTDER: w = '{DP_INTDER, H_NONE,     J_NEXT,       PC_FETCH};
      PC_MUL_P:  w = '{DP_MUL_P,  H_NONE,     J_NEXT,       PC_FETCH};
      PC_MUL_I:  w = '{DP_MUL_I,  H_NONE,     J_NEXT,       PC_FETCH};
      PC_MUL_D:  w = '{DP_MUL_D,  H_NONE,     J_NEXT,       PC_FETCH};
      PC_ACC:    w = '{DP_ACC,    H_NONE,     J_NEXT,       PC_FETCH};
      PC_DIV:    w = '{DP_DIV,    H_NONE,     J_NEXT,       PC_FETCH};
      PC_MAP:    w = '{DP_MAP,    H_NONE,     J_NEXT,       PC_FETCH};
      PC_STEP:   w = '{DP_STEP,   H_NONE,     J_NEXT,       PC_FETCH};
      PC_SLEW:   w = '{DP_SLEW,   H_NONE,     J_IN_REACH,   PC_EMIT};
      PC_QUO:    w = '{DP_QUO,    H_NONE,     J_NEXT,       PC_FETCH};
      PC_EMIT:   w = '{DP_EMIT,   H_OUT_FULL, J_ALWAYS,     PC_FETCH};
      PC_SET:    w = '{DP_SET,    H_NONE,     J_ALWAYS,     PC_EMIT};
      default:   w = '{DP_NOP,    H_NONE,     J_ALWAYS,     PC_FETCH};
    endcase
    return w;
  endfunction

endpackage

[sv/pid_position_motor_drive.sv]
// ----------------------------------------------------------------------------
// pid_position_motor_drive
// Position PID with slew-limited speed and forward/reverse duty outputs.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake           payload
//   in_       in          in_valid/in_stall   in_t  (op, command, positions, ms)
//   out_      out         out_valid/out_stall out_t (speed, forward, reverse duty)
//   cfg_      in          cfg_valid/cfg_ready index 0..3, 16-bit data
//
// A microcoded sequencer steps a shared datapath through one item at a time.
// A full control tick runs error, integral and derivative, three products on
// the single shared multiplier, accumulate, divide, map, step and slew steps,
// plus the quotient step unless the target speed is within one slew step. A
// set-speed item or a tick at zero speed skips the PID steps. The result
// register frees the input side while a result waits; a stalled result holds
// the sequencer at its emit step. Synchronous reset clears speed, integral and
// previous error, restores the register defaults and returns to the fetch step.
//
module pid_position_motor_drive import pidm_pkg::*; #(
  parameter int POSITION_BITS      = POSITION_BITS_DEF,
  parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_t                       in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_t                      out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [15:0]               cfg_data
);

  ctrl_t ctrl;
  stat_t stat;
  cfg_t  cfg;

  // Take inputs and register writes only at the fetch step
  assign in_stall  = (ctrl.op != DP_LOAD);
  assign cfg_ready = (ctrl.op == DP_LOAD);

  pidm_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pidm_sequencer u_sequencer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  pidm_datapath #(
    .POSITION_BITS      (POSITION_BITS),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .in_data   (in_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[sv/pidm_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pidm_cfg_regs
// Gain and acceleration registers, written over the configuration port.
// ----------------------------------------------------------------------------
module pidm_cfg_regs import pidm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [15:0]               wr_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_GAIN_P:       cfg_nxt.gain_p       = signed'(wr_data);
        REG_GAIN_I:       cfg_nxt.gain_i       = signed'(wr_data);
        REG_GAIN_D:       cfg_nxt.gain_d       = signed'(wr_data);
        REG_ACCELERATION: cfg_nxt.acceleration = wr_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p       <= GAIN_P_RESET;
      cfg_r.gain_i       <= GAIN_I_RESET;
      cfg_r.gain_d       <= GAIN_D_RESET;
      cfg_r.acceleration <= ACCELERATION_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/pidm_sequencer.sv]
// ----------------------------------------------------------------------------
// pidm_sequencer
// Step counter over the control store, with hold and jump conditions.
// ----------------------------------------------------------------------------
module pidm_sequencer import pidm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [PC_BITS-1:0] pc_r;
  logic [PC_BITS-1:0] pc_nxt;
  ucode_t             word;
  logic               hold_on;
  logic               jump_on;

  // Fetch the current control word
  assign word = ucode_rom(pc_r);

  // Evaluate the hold condition
  always_comb begin
    case (word.hold)
      H_NONE:     hold_on = 1'b0;
      H_NO_INPUT: hold_on = !in_valid;
      H_OUT_FULL: hold_on = stat.out_full;
      default:    hold_on = 1'b0;
    endcase
  end

  // Evaluate the jump condition
  always_comb begin
    case (word.jump)
      J_NEXT:       jump_on = 1'b0;
      J_ALWAYS:     jump_on = 1'b1;
      J_IS_SET:     jump_on = stat.is_set;
      J_SPEED_ZERO: jump_on = stat.speed_zero;
      J_IN_REACH:   jump_on = stat.in_reach;
      default:      jump_on = 1'b0;
    endcase
  end

  // Advance, jump or hold
  always_comb begin
    if (hold_on) begin
      pc_nxt = pc_r;
    end else if (jump_on) begin
      pc_nxt = word.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.op   = word.op;
  assign ctrl.exec = !hold_on;

endmodule

[sv/pidm_datapath.sv]
// ----------------------------------------------------------------------------
// pidm_datapath
// PID, speed mapping, slew limit and duty registers, one operation per step.
// ----------------------------------------------------------------------------
module pidm_datapath import pidm_pkg::*; #(
  parameter int POSITION_BITS      = POSITION_BITS_DEF,
  parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  ctrl_t ctrl,
  input  cfg_t  cfg,
  input  in_t   in_data,
  input  logic  out_stall,
  output stat_t stat,
  output logic  out_valid,
  output out_t  out_data
);

  localparam int PB     = POSITION_BITS;
  localparam int WW     = (PB + 1 > 33) ? PB + 1 : 33;
  localparam int PW     = PB + 16;
  localparam int ACC_W  = 64;

  localparam logic signed [WW-1:0]    POS_MAX   = WW'((64'sd1 <<< (PB - 1)) - 64'sd1);
  localparam logic signed [WW-1:0]    POS_MIN   = ~POS_MAX;
  localparam logic signed [ACC_W-1:0] PROD_LIM  = 64'sd1 <<< 61;
  localparam logic signed [ACC_W-1:0] DIV_ROUND =
    (64'sd1 <<< GAIN_FRACTION_BITS) - 64'sd1;

  // Reciprocals: x*200/510, x/1000 and y*51/20
  localparam logic [28:0] MAP_RECIP = 29'd411207;
  localparam logic [38:0] QUO_RECIP = 39'd536871;
  localparam logic [25:0] PWM_RECIP = 26'd167117;

  function automatic logic signed [PB-1:0] sat_pos(input logic signed [WW-1:0] v);
    logic signed [PB-1:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX[PB-1:0];
    end else if (v < POS_MIN) begin
      r = POS_MIN[PB-1:0];
    end else begin
      r = v[PB-1:0];
    end
    return r;
  endfunction

  // Latched input item
  logic                     op_r,   op_nxt;
  logic signed [15:0]       cmd_r,  cmd_nxt;
  logic signed [31:0]       tpos_r, tpos_nxt;
  logic signed [31:0]       mpos_r, mpos_nxt;
  logic        [15:0]       ems_r,  ems_nxt;

  // Controller state
  logic signed [7:0]        speed_r, speed_nxt;
  logic signed [PB-1:0]     integ_r, integ_nxt;
  logic signed [PB-1:0]     prev_r,  prev_nxt;

  // Work registers
  logic signed [PB-1:0]     err_r,    err_nxt;
  logic signed [PB-1:0]     deriv_r,  deriv_nxt;
  logic signed [PW-1:0]     prod_r,   prod_nxt;
  logic signed [ACC_W-1:0]  acc_r,    acc_nxt;
  logic signed [8:0]        pid_r,    pid_nxt;
  logic signed [7:0]        tgt_r,    tgt_nxt;
  logic        [31:0]       step_r,   step_nxt;
  logic        [7:0]        diff_r,   diff_nxt;
  logic signed [19:0]       scaled_r, scaled_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  out_t                     out_data_r,  out_data_nxt;

  // Combinational terms
  logic signed [WW-1:0]     err_wide;
  logic signed [WW-1:0]     integ_sum;
  logic signed [WW-1:0]     deriv_wide;
  logic signed [15:0]       mul_gain;
  logic signed [PB-1:0]     mul_opnd;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  prod_sat;
  logic signed [ACC_W-1:0]  div_bias;
  logic signed [ACC_W-1:0]  div_q;
  logic signed [8:0]        pid_sat;
  logic        [9:0]        map_x;
  logic        [28:0]       map_prod;
  logic        [8:0]        map_q;
  logic signed [8:0]        dif9;
  logic signed [8:0]        dif_abs;
  logic        [17:0]       diff_k;
  logic                     in_reach;
  logic                     move_up;
  logic signed [19:0]       spd_k;
  logic signed [19:0]       step_s;
  logic        [18:0]       quo_mag;
  logic        [38:0]       quo_prod;
  logic        [9:0]        quo_q;
  logic        [6:0]        quo_lim;
  logic signed [7:0]        quo_speed;
  logic signed [7:0]        set_speed;
  logic        [7:0]        pwm_y;
  logic        [25:0]       pwm_prod;
  logic        [9:0]        pwm_q;
  out_t                     emit_data;

  // Position error, integral and derivative
  assign err_wide   = WW'(tpos_r) - WW'(mpos_r);
  assign integ_sum  = WW'(integ_r) + WW'(err_r);
  assign deriv_wide = WW'(err_r) - WW'(prev_r);

  // Select the gain and operand of the shared multiplier
  always_comb begin
    case (ctrl.op)
      DP_MUL_I: begin
        mul_gain = cfg.gain_i;
        mul_opnd = integ_r;
      end
      DP_MUL_D: begin
        mul_gain = cfg.gain_d;
        mul_opnd = deriv_r;
      end
      default: begin
        mul_gain = cfg.gain_p;
        mul_opnd = err_r;
      end
    endcase
  end

  // Clamp the previous product before accumulating it
  assign prod_ext = ACC_W'(prod_r);
  always_comb begin
    if (prod_ext > PROD_LIM) begin
      prod_sat = PROD_LIM;
    end else if (prod_ext < -PROD_LIM) begin
      prod_sat = -PROD_LIM;
    end else begin
      prod_sat = prod_ext;
    end
  end

  // Drop the gain fraction, truncating toward zero, and saturate
  assign div_bias = acc_r + (acc_r[ACC_W-1] ? DIV_ROUND : 64'sd0);
  assign div_q    = div_bias >>> GAIN_FRACTION_BITS;
  always_comb begin
    if (div_q > 64'sd255) begin
      pid_sat = 9'sd255;
    end else if (div_q < -64'sd255) begin
      pid_sat = -9'sd255;
    end else begin
      pid_sat = div_q[8:0];
    end
  end

  // Map -255..255 onto -100..100
  assign map_x    = 10'(11'(pid_r) + 11'sd255);
  assign map_prod = 29'(map_x) * MAP_RECIP;
  assign map_q    = map_prod[28:20];

  // Distance to the target speed
  assign dif9    = 9'(speed_r) - 9'(tgt_r);
  assign dif_abs = dif9[8] ? -dif9 : dif9;

  // Slew limit: compare in thousandths, then step toward the target
  assign diff_k   = 18'(diff_r) * 18'd1000;
  assign in_reach = (32'(diff_k) <= step_r);
  assign move_up  = (speed_r < tgt_r);
  assign spd_k    = 20'(speed_r) * 20'sd1000;
  assign step_s   = signed'(20'(step_r[17:0]));

  // Divide the scaled speed by 1000 toward zero
  assign quo_mag   = scaled_r[19] ? 19'(-scaled_r) : 19'(scaled_r);
  assign quo_prod  = 39'(quo_mag) * QUO_RECIP;
  assign quo_q     = quo_prod[38:29];
  assign quo_lim   = (quo_q > 10'd100) ? 7'd100 : quo_q[6:0];
  assign quo_speed = scaled_r[19] ? -signed'({1'b0, quo_lim}) : signed'({1'b0, quo_lim});

  // Clamp a direct speed command
  always_comb begin
    if (cmd_r > 16'sd100) begin
      set_speed = 8'sd100;
    end else if (cmd_r < -16'sd100) begin
      set_speed = -8'sd100;
    end else begin
      set_speed = cmd_r[7:0];
    end
  end

  // Duty pair from the speed
  assign pwm_y    = 8'(9'(speed_r) + 9'sd100);
  assign pwm_prod = 26'(pwm_y) * PWM_RECIP;
  assign pwm_q    = pwm_prod[25:16];
  always_comb begin
    emit_data.speed        = speed_r;
    emit_data.forward_duty = (pwm_q > 10'd255) ? 8'(pwm_q - 10'd255) : 8'd0;
    emit_data.reverse_duty = (pwm_q < 10'd255) ? 8'(10'd255 - pwm_q) : 8'd0;
  end

  // Execute the operation of the current step
  always_comb begin
    op_nxt        = op_r;
    cmd_nxt       = cmd_r;
    tpos_nxt      = tpos_r;
    mpos_nxt      = mpos_r;
    ems_nxt       = ems_r;
    speed_nxt     = speed_r;
    integ_nxt     = integ_r;
    prev_nxt      = prev_r;
    err_nxt       = err_r;
    deriv_nxt     = deriv_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    pid_nxt       = pid_r;
    tgt_nxt       = tgt_r;
    step_nxt      = step_r;
    diff_nxt      = diff_r;
    scaled_nxt    = scaled_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    // Drop the result once the transfer completes
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (ctrl.exec) begin
      case (ctrl.op)
        DP_LOAD: begin
          op_nxt   = in_data.op;
          cmd_nxt  = in_data.speed_command;
          tpos_nxt = in_data.target_position;
          mpos_nxt = in_data.measured_position;
          ems_nxt  = in_data.elapsed_ms;
        end
        DP_SET: begin
          speed_nxt = set_speed;
        end
        DP_ERR: begin
          err_nxt = sat_pos(err_wide);
        end
        DP_INTDER: begin
          integ_nxt = sat_pos(integ_sum);
          deriv_nxt = sat_pos(deriv_wide);
          prev_nxt  = err_r;
        end
        DP_MUL_P: begin
          prod_nxt = PW'(mul_gain) * PW'(mul_opnd);
        end
        DP_MUL_I: begin
          acc_nxt  = prod_sat;
          prod_nxt = PW'(mul_gain) * PW'(mul_opnd);
        end
        DP_MUL_D: begin
          acc_nxt  = acc_r + prod_sat;
          prod_nxt = PW'(mul_gain) * PW'(mul_opnd);
        end
        DP_ACC: begin
          acc_nxt = acc_r + prod_sat;
        end
        DP_DIV: begin
          pid_nxt = pid_sat;
        end
        DP_MAP: begin
          tgt_nxt = signed'(8'(map_q) - 8'd100);
        end
        DP_STEP: begin
          step_nxt = 32'(cfg.acceleration) * 32'(ems_r);
          diff_nxt = dif_abs[7:0];
        end
        DP_SLEW: begin
          if (in_reach) begin
            speed_nxt = tgt_r;
          end else begin
            scaled_nxt = move_up ? spd_k + step_s : spd_k - step_s;
          end
        end
        DP_QUO: begin
          speed_nxt = quo_speed;
        end
        DP_EMIT: begin
          out_data_nxt  = emit_data;
          out_valid_nxt = 1'b1;
        end
        default: begin
          op_nxt = op_r;
        end
      endcase
    end
  end

  // Control and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= '0;
      integ_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      speed_r     <= speed_nxt;
      integ_r     <= integ_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    cmd_r      <= cmd_nxt;
    tpos_r     <= tpos_nxt;
    mpos_r     <= mpos_nxt;
    ems_r      <= ems_nxt;
    err_r      <= err_nxt;
    deriv_r    <= deriv_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    pid_r      <= pid_nxt;
    tgt_r      <= tgt_nxt;
    step_r     <= step_nxt;
    diff_r     <= diff_nxt;
    scaled_r   <= scaled_nxt;
    out_data_r <= out_data_nxt;
  end

  assign stat.is_set     = op_r;
  assign stat.speed_zero = (speed_r == 8'sd0);
  assign stat.in_reach   = in_reach;
  assign stat.out_full   = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/pidm_checker.sv]
// ----------------------------------------------------------------------------
// pidm_checker
// Port-level checks of the position motor drive, bound to the top level.
// ----------------------------------------------------------------------------
module pidm_checker import pidm_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One item at a time: busy right after an input transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transfer");

  // Reported speed stays within the command range
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.speed >= -8'sd100 && out_data.speed <= 8'sd100))
    else $error("speed out of range");

  // Duty legs agree with the speed sign
  a_duty_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.speed > 8'sd0 && out_data.forward_duty != 8'd0 &&
                    out_data.reverse_duty == 8'd0) ||
                   (out_data.speed < 8'sd0 && out_data.reverse_duty != 8'd0 &&
                    out_data.forward_duty == 8'd0) ||
                   (out_data.speed == 8'sd0 && out_data.forward_duty == 8'd0 &&
                    out_data.reverse_duty == 8'd0)))
    else $error("duty pair disagrees with speed");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind pid_position_motor_drive pidm_checker u_pidm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
